// ===== rtl/fucc_pkg.sv =====
// Shared types and constants for the frame unstuff / checksum check block.
// No dependencies.
`timescale 1ns / 1ps

package fucc_pkg;

  // Final frame status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_HEADER   = 2'd1,
    ST_CHK_MISMATCH = 2'd2,
    ST_TOO_SHORT    = 2'd3
  } status_e;

  // Configuration register indexes
  localparam logic CFG_HEADER_BYTE = 1'b0;
  localparam logic CFG_STUFF_BYTE  = 1'b1;

  // Configuration reset values
  localparam logic [7:0] HEADER_BYTE_RST = 8'hFF;
  localparam logic [7:0] STUFF_BYTE_RST  = 8'h55;

  // Header position: first byte, second byte, then body
  localparam logic [1:0] HDR_FIRST = 2'd0;
  localparam logic [1:0] HDR_BODY  = 2'd2;

  localparam logic [7:0] TALLY_MAX = 8'hFF;

endpackage

// ===== rtl/frame_unstuff_checksum_check_top.sv =====
// Deframer: header check, byte destuffing and additive checksum check.
// Depends on fucc_pkg.
`timescale 1ns / 1ps

// One raw byte is taken per transfer, one per clock cycle when the output
// side keeps up. Each accepted byte updates the frame state in the cycle of
// its transfer and its result, if any, is registered and shown the next cycle;
// a byte is accepted while a result waits, as long as that result is taken in
// the same cycle (in_ready_o = !out_valid_o | out_ready_i). Destuffed body
// bytes appear one destuffed byte late; the byte flagged frame_end always
// yields one final result carrying the checksum, the status and the body
// count. Configuration writes take effect on the next cycle and should be
// made only while no frame is in flight.
module frame_unstuff_checksum_check_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // raw byte input
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] raw_byte_i,
  input  logic       frame_end_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       final_flag_o,
  output logic [1:0] frame_status_o,
  output logic [7:0] body_count_o
);

  // Configuration registers
  logic [7:0] header_byte_q;
  logic [7:0] stuff_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= fucc_pkg::HEADER_BYTE_RST;
      stuff_byte_q  <= fucc_pkg::STUFF_BYTE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fucc_pkg::CFG_HEADER_BYTE: header_byte_q <= cfg_data_i;
        fucc_pkg::CFG_STUFF_BYTE:  stuff_byte_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state
  logic [1:0] hdr_pos_q,      hdr_pos_d;
  logic       hdr_good_q,     hdr_good_d;
  logic       prior_mark_q,   prior_mark_d;
  logic       held_valid_q,   held_valid_d;
  logic [7:0] held_byte_q,    held_byte_d;
  logic [7:0] run_sum_q,      run_sum_d;
  logic [7:0] tally_q,        tally_d;

  // Result register
  logic       out_valid_q,  out_valid_d;
  logic [7:0] out_data_q,   out_data_d;
  logic       out_final_q,  out_final_d;
  logic [1:0] out_status_q, out_status_d;
  logic [7:0] out_count_q,  out_count_d;

  logic       in_fire;
  logic       in_body;
  logic       drop_stuff;
  logic       have_new;
  logic       any_body;
  logic       good_now;
  logic [7:0] sum_fin;
  logic [7:0] chk_byte;
  fucc_pkg::status_e status_fin;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Classify the incoming byte
  always_comb begin
    in_body    = (hdr_pos_q == fucc_pkg::HDR_BODY);
    drop_stuff = in_body && prior_mark_q && (raw_byte_i == stuff_byte_q);
    have_new   = in_body && !drop_stuff;
    good_now   = hdr_good_q && (in_body || (raw_byte_i == header_byte_q));
    any_body   = have_new || held_valid_q;
    sum_fin    = run_sum_q + ((have_new && held_valid_q) ? held_byte_q : 8'd0);
    if (have_new) begin
      chk_byte = raw_byte_i;
    end else if (held_valid_q) begin
      chk_byte = held_byte_q;
    end else begin
      chk_byte = 8'd0;
    end
    // bad header over too short over mismatch
    if (!good_now) begin
      status_fin = fucc_pkg::ST_BAD_HEADER;
    end else if (!any_body) begin
      status_fin = fucc_pkg::ST_TOO_SHORT;
    end else if (sum_fin != chk_byte) begin
      status_fin = fucc_pkg::ST_CHK_MISMATCH;
    end else begin
      status_fin = fucc_pkg::ST_OK;
    end
  end

  // Next frame state and result
  always_comb begin
    hdr_pos_d    = hdr_pos_q;
    hdr_good_d   = hdr_good_q;
    prior_mark_d = prior_mark_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    run_sum_d    = run_sum_q;
    tally_d      = tally_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    out_final_d  = out_final_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    if (in_fire) begin
      if (!in_body) begin
        hdr_pos_d  = hdr_pos_q + 2'd1;
        hdr_good_d = good_now;
      end else if (drop_stuff) begin
        prior_mark_d = 1'b0;
      end else begin
        prior_mark_d = (raw_byte_i == header_byte_q);
        if (tally_q != fucc_pkg::TALLY_MAX) begin
          tally_d = tally_q + 8'd1;
        end
      end

      out_count_d = tally_d;
      if (frame_end_i) begin
        // final result, then back to the start of a frame
        out_valid_d  = 1'b1;
        out_data_d   = chk_byte;
        out_final_d  = 1'b1;
        out_status_d = status_fin;
        hdr_pos_d    = fucc_pkg::HDR_FIRST;
        hdr_good_d   = 1'b1;
        prior_mark_d = 1'b0;
        held_valid_d = 1'b0;
        held_byte_d  = 8'd0;
        run_sum_d    = 8'd0;
        tally_d      = 8'd0;
      end else if (have_new) begin
        // release the held byte, hold the new one
        out_valid_d  = held_valid_q;
        out_data_d   = held_byte_q;
        out_final_d  = 1'b0;
        out_status_d = fucc_pkg::ST_OK;
        if (held_valid_q) begin
          run_sum_d = run_sum_q + held_byte_q;
        end
        held_byte_d  = raw_byte_i;
        held_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // Control and frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q    <= fucc_pkg::HDR_FIRST;
      hdr_good_q   <= 1'b1;
      prior_mark_q <= 1'b0;
      held_valid_q <= 1'b0;
      held_byte_q  <= 8'd0;
      run_sum_q    <= 8'd0;
      tally_q      <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      hdr_pos_q    <= hdr_pos_d;
      hdr_good_q   <= hdr_good_d;
      prior_mark_q <= prior_mark_d;
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      run_sum_q    <= run_sum_d;
      tally_q      <= tally_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_final_q  <= out_final_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_data_q;
  assign final_flag_o   = out_final_q;
  assign frame_status_o = out_status_q;
  assign body_count_o   = out_count_q;

  // A held byte only exists once the header is behind us
  a_held_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (hdr_pos_q == fucc_pkg::HDR_BODY))
    else $error("held byte outside frame body");

  // Frame state is cleared after a frame end transfer
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && frame_end_i) |=> (hdr_pos_q == fucc_pkg::HDR_FIRST) && !held_valid_q
      && (tally_q == 8'd0) && (run_sum_q == 8'd0))
    else $error("frame state not cleared after frame end");

  // Data results carry ok status and at least two body bytes
  a_data_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_final_q) |->
      (out_status_q == fucc_pkg::ST_OK) && (out_count_q >= 8'd2))
    else $error("malformed data result");

  // A good or mismatching frame had at least one body byte
  a_final_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_final_q && (out_status_q == fucc_pkg::ST_OK ||
      out_status_q == fucc_pkg::ST_CHK_MISMATCH)) |-> (out_count_q != 8'd0))
    else $error("checked frame without body bytes");

  // A final result always comes from a frame end transfer
  a_final_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !frame_end_i) |=> !(out_valid_q && out_final_q))
    else $error("final result without frame end");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for frame_unstuff_checksum_check_top: header check, destuffing, checksum status.
// Depends on fucc_pkg and the top-level RTL. Results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // One result of the deframer
  typedef struct packed {
    logic [7:0]        data_byte;
    logic              final_flag;
    fucc_pkg::status_e frame_status;
    logic [7:0]        body_count;
  } result_t;

  // DUT ports
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_index_i    = fucc_pkg::CFG_HEADER_BYTE;
  logic [7:0] cfg_data_i     = 8'h00;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] raw_byte_i     = 8'h00;
  logic       frame_end_i    = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] data_byte_o;
  logic       final_flag_o;
  logic [1:0] frame_status_o;
  logic [7:0] body_count_o;

  // Predictor copy of the configuration and frame state
  logic [7:0] hdr_val;
  logic [7:0] stuff_val;
  logic [1:0] hdr_pos;
  logic       hdr_ok;
  logic       after_marker;
  logic       pending_valid;
  logic [7:0] pending_byte;
  logic [7:0] body_sum;
  logic [7:0] body_cnt;

  result_t     deframed_q[$];
  int unsigned err_cnt        = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  frame_unstuff_checksum_check_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_byte_i     (raw_byte_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .final_flag_o   (final_flag_o),
    .frame_status_o (frame_status_o),
    .body_count_o   (body_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void clear_frame_state();
    hdr_pos       = fucc_pkg::HDR_FIRST;
    hdr_ok        = 1'b1;
    after_marker  = 1'b0;
    pending_valid = 1'b0;
    pending_byte  = 8'h00;
    body_sum      = 8'h00;
    body_cnt      = 8'h00;
  endfunction

  // Predict the results of one accepted raw byte
  function automatic void deframe_byte(logic [7:0] raw, logic last);
    logic       fresh;
    logic       any;
    logic [7:0] chk;
    logic [7:0] sum;
    result_t    r;
    fresh = 1'b0;
    if (hdr_pos != fucc_pkg::HDR_BODY) begin
      if (raw != hdr_val) hdr_ok = 1'b0;
      hdr_pos = hdr_pos + 2'd1;
    end else if (after_marker && raw == stuff_val) begin
      // stuff byte behind a header-valued byte is dropped
      after_marker = 1'b0;
    end else begin
      fresh        = 1'b1;
      after_marker = (raw == hdr_val);
      if (body_cnt != fucc_pkg::TALLY_MAX) body_cnt = body_cnt + 8'd1;
    end

    if (last) begin
      sum = body_sum;
      chk = 8'h00;
      any = 1'b1;
      if (fresh) begin
        // held byte joins the sum but is never shown
        if (pending_valid) sum = sum + pending_byte;
        chk = raw;
      end else if (pending_valid) begin
        chk = pending_byte;
      end else begin
        any = 1'b0;
      end
      r.data_byte  = chk;
      r.final_flag = 1'b1;
      r.body_count = body_cnt;
      if (!hdr_ok)         r.frame_status = fucc_pkg::ST_BAD_HEADER;
      else if (!any)       r.frame_status = fucc_pkg::ST_TOO_SHORT;
      else if (sum != chk) r.frame_status = fucc_pkg::ST_CHK_MISMATCH;
      else                 r.frame_status = fucc_pkg::ST_OK;
      deframed_q.push_back(r);
      clear_frame_state();
    end else if (fresh) begin
      if (pending_valid) begin
        r.data_byte    = pending_byte;
        r.final_flag   = 1'b0;
        r.frame_status = fucc_pkg::ST_OK;
        r.body_count   = body_cnt;
        deframed_q.push_back(r);
        body_sum = body_sum + pending_byte;
      end
      pending_byte  = raw;
      pending_valid = 1'b1;
    end
  endfunction

  // Compare each result transfer, then predict from each input transfer
  always @(posedge clk_i) begin : check_blk
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (deframed_q.size() == 0) begin
        $error("unexpected result: data_byte %0d final_flag %0d frame_status %0d body_count %0d",
               data_byte_o, final_flag_o, frame_status_o, body_count_o);
        err_cnt++;
      end else begin
        want = deframed_q.pop_front();
        if (data_byte_o !== want.data_byte) begin
          $error("data_byte: expected %0d, actual %0d", want.data_byte, data_byte_o);
          err_cnt++;
        end
        if (final_flag_o !== want.final_flag) begin
          $error("final_flag: expected %0d, actual %0d", want.final_flag, final_flag_o);
          err_cnt++;
        end
        if (frame_status_o !== want.frame_status) begin
          $error("frame_status: expected %0d, actual %0d", want.frame_status, frame_status_o);
          err_cnt++;
        end
        if (body_count_o !== want.body_count) begin
          $error("body_count: expected %0d, actual %0d", want.body_count, body_count_o);
          err_cnt++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) deframe_byte(raw_byte_i, frame_end_i);
  end

  // Offer one raw byte and hold it until its transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_byte_i  <= b;
    frame_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stop sending and wait until every expected result has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == fucc_pkg::CFG_HEADER_BYTE) hdr_val = value;
    else                                  stuff_val = value;
  endtask

  task automatic set_config(input logic [7:0] hdr, input logic [7:0] stuff);
    write_reg(fucc_pkg::CFG_HEADER_BYTE, hdr);
    write_reg(fucc_pkg::CFG_STUFF_BYTE, stuff);
  endtask

  // Random byte, biased toward the header and stuff values
  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return hdr_val;
    if (roll < 40) return stuff_val;
    return 8'($urandom_range(255));
  endfunction

  // Build and send one frame: header, stuffed body, checksum.
  // Faults: a flipped header bit, a wrong checksum, or a cut at a random byte.
  task automatic send_frame(input int unsigned body_len, input bit hdr_err,
                            input bit chk_err, input bit cut_short);
    logic [7:0]  raw_q[$];
    logic [7:0]  b;
    logic [7:0]  sum;
    int unsigned bad_pos;
    int unsigned keep;
    sum     = 8'h00;
    bad_pos = $urandom_range(1);
    for (int i = 0; i < 2; i++) begin
      raw_q.push_back((hdr_err && i == bad_pos) ? hdr_val ^ (8'h01 << $urandom_range(7))
                                                : hdr_val);
    end
    for (int i = 0; i <= body_len; i++) begin
      if (i == body_len) begin
        b = chk_err ? sum + 8'($urandom_range(1, 255)) : sum;
      end else begin
        b   = pick_byte();
        sum = sum + b;
      end
      raw_q.push_back(b);
      // stuffing is left out now and then
      if (b == hdr_val && $urandom_range(19) != 0) raw_q.push_back(stuff_val);
    end
    keep = cut_short ? $urandom_range(1, raw_q.size()) : raw_q.size();
    for (int i = 0; i < keep; i++) send_byte(raw_q[i], i == keep - 1);
  endtask

  // Hand-picked frames under the reset configuration
  task automatic test_basic_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // good frame, one data byte then the report
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b1);
    // stuffed body byte, zero byte in the body
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h55, 1'b0); send_byte(8'hFF, 1'b1);
    // no body byte at all
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
    // frame ends on a bad first header byte
    send_byte(8'h00, 1'b1);
    // bad header, body still destuffed
    send_byte(8'hFF, 1'b0); send_byte(8'h7E, 1'b0);
    send_byte(8'h10, 1'b0); send_byte(8'h10, 1'b1);
    // last raw byte is a dropped stuff byte
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h55, 1'b1);
    // frame ends on a good first header byte
    send_byte(8'hFF, 1'b1);
  endtask

  // Bodies past the point where the count saturates
  task automatic test_long_body();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame(256, 1'b0, 1'b0, 1'b0);
    send_frame(262, 1'b0, 1'b1, 1'b0);
  endtask

  // Random frames over several configurations and idle patterns
  task automatic test_random_traffic(input int unsigned item_goal);
    int unsigned send_modes[4] = '{0, 61, 0, 14};
    int unsigned recv_modes[4] = '{0, 0, 61, 14};
    int unsigned phase;
    int unsigned stop_at;
    int unsigned phase_end;
    int unsigned roll;
    int unsigned len;
    logic [7:0]  hdr_pick;
    logic [7:0]  stuff_pick;
    phase   = 0;
    stop_at = bytes_sent + item_goal;
    while (bytes_sent < stop_at) begin
      case (phase)
        0:       begin hdr_pick = 8'h00; stuff_pick = 8'hFF; end
        1:       begin hdr_pick = 8'hFF; stuff_pick = 8'h00; end
        2:       begin hdr_pick = 8'hAA; stuff_pick = 8'hAA; end
        3:       begin hdr_pick = 8'h00; stuff_pick = 8'h00; end
        default: begin
          hdr_pick   = 8'($urandom_range(255));
          stuff_pick = 8'($urandom_range(255));
        end
      endcase
      wait_drained();
      set_config(hdr_pick, stuff_pick);
      send_idle_pct  = send_modes[phase % 4];
      recv_stall_pct = recv_modes[phase % 4];
      phase_end      = bytes_sent + 60;
      while (bytes_sent < phase_end && bytes_sent < stop_at) begin
        roll = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        if (roll < 75)      send_frame(len, 1'b0, 1'b0, 1'b0);
        else if (roll < 83) send_frame(len, 1'b1, 1'($urandom_range(1)), 1'b0);
        else if (roll < 89) send_frame(len, 1'b0, 1'b1, 1'b0);
        else if (roll < 94) send_frame(len, 1'($urandom_range(1)), 1'b0, 1'b1);
        else if (roll < 97) begin
          // raw noise, always closed by a frame end
          len = $urandom_range(1, 10);
          for (int k = 1; k <= len; k++) begin
            send_byte(pick_byte(), k == len || $urandom_range(9) == 0);
          end
        end else begin
          wait_drained();
        end
      end
      phase++;
    end
  endtask

  initial begin
    hdr_val   = fucc_pkg::HEADER_BYTE_RST;
    stuff_val = fucc_pkg::STUFF_BYTE_RST;
    clear_frame_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_frames();
    test_long_body();
    test_random_traffic(650);
    wait_drained();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fucc_pkg.sv
rtl/frame_unstuff_checksum_check_top.sv
sim/tb_top.sv
